// ===== design/twhsm_pkg.sv =====
package twhsm_pkg;

  // Register byte addresses on the configuration port
  localparam int unsigned AddrWidth = 5;
  localparam logic [AddrWidth-1:0] ADDR_HALF_PERIOD = 5'h00;
  localparam logic [AddrWidth-1:0] ADDR_TIMEOUT     = 5'h04;
  localparam logic [AddrWidth-1:0] ADDR_TEMP_CMD    = 5'h08;
  localparam logic [AddrWidth-1:0] ADDR_HUM_CMD     = 5'h0C;
  localparam logic [AddrWidth-1:0] ADDR_SRST_CMD    = 5'h10;

  // Reset values of the registers
  localparam logic [11:0] HALF_PERIOD_RESET = 12'd5;
  localparam logic [15:0] TIMEOUT_RESET     = 16'hFFFF;
  localparam logic [7:0]  TEMP_CMD_RESET    = 8'h03;
  localparam logic [7:0]  HUM_CMD_RESET     = 8'h05;
  localparam logic [7:0]  SRST_CMD_RESET    = 8'h1E;

  // Clock pulses with DATA high in a connection reset
  localparam logic [3:0] RESET_CLOCKS = 4'd9;

  // Start pattern length, steps 0 to TS_LAST
  localparam logic [2:0] TS_LAST = 3'd6;

  // Action codes
  localparam logic [1:0] ACT_CONN_RESET = 2'd0;
  localparam logic [1:0] ACT_SOFT_RESET = 2'd1;
  localparam logic [1:0] ACT_TEMP       = 2'd2;
  localparam logic [1:0] ACT_HUM        = 2'd3;

  typedef struct packed {
    logic [11:0] half_period_ticks;
    logic [15:0] ready_timeout_polls;
    logic [7:0]  temperature_command;
    logic [7:0]  humidity_command;
    logic [7:0]  soft_reset_command;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] action;
    logic       data_sample;
  } tick_t;

  typedef struct packed {
    logic        clock_level;
    logic        data_drive_enable;
    logic        data_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] measurement;
    logic [7:0]  check_byte;
    logic [1:0]  error_count;
  } result_t;

  // SCK level of each start pattern step
  function automatic logic ts_clock(input logic [2:0] step);
    logic lvl;
    unique case (step)
      3'd1, 3'd2, 3'd4, 3'd5: lvl = 1'b1;
      default:                lvl = 1'b0;
    endcase
    return lvl;
  endfunction

  // DATA level of each start pattern step
  function automatic logic ts_data(input logic [2:0] step);
    logic lvl;
    unique case (step)
      3'd0, 3'd1, 3'd5, 3'd6: lvl = 1'b1;
      default:                lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

// ===== design/twhsm_regs.sv =====
module twhsm_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [twhsm_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output twhsm_pkg::cfg_t                 cfg
);
  import twhsm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks   <= HALF_PERIOD_RESET;
      cfg.ready_timeout_polls <= TIMEOUT_RESET;
      cfg.temperature_command <= TEMP_CMD_RESET;
      cfg.humidity_command    <= HUM_CMD_RESET;
      cfg.soft_reset_command  <= SRST_CMD_RESET;
    end else if (wr_en) begin
      unique case (paddr)
        ADDR_HALF_PERIOD: cfg.half_period_ticks   <= pwdata[11:0];
        ADDR_TIMEOUT:     cfg.ready_timeout_polls <= pwdata[15:0];
        ADDR_TEMP_CMD:    cfg.temperature_command <= pwdata[7:0];
        ADDR_HUM_CMD:     cfg.humidity_command    <= pwdata[7:0];
        ADDR_SRST_CMD:    cfg.soft_reset_command  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_HALF_PERIOD: prdata = {20'd0, cfg.half_period_ticks};
      ADDR_TIMEOUT:     prdata = {16'd0, cfg.ready_timeout_polls};
      ADDR_TEMP_CMD:    prdata = {24'd0, cfg.temperature_command};
      ADDR_HUM_CMD:     prdata = {24'd0, cfg.humidity_command};
      ADDR_SRST_CMD:    prdata = {24'd0, cfg.soft_reset_command};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/twhsm_seq.sv =====
module twhsm_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  twhsm_pkg::tick_t     tick,
  input  twhsm_pkg::cfg_t      cfg,
  output twhsm_pkg::result_t   res
);
  import twhsm_pkg::*;

  typedef enum logic [11:0] {
    PH_IDLE   = 12'b0000_0000_0001,
    PH_RST_HI = 12'b0000_0000_0010,
    PH_RST_LO = 12'b0000_0000_0100,
    PH_TS     = 12'b0000_0000_1000,
    PH_WB_HI  = 12'b0000_0001_0000,
    PH_WB_LO  = 12'b0000_0010_0000,
    PH_WACK   = 12'b0000_0100_0000,
    PH_POLL   = 12'b0000_1000_0000,
    PH_RB_HI  = 12'b0001_0000_0000,
    PH_RB_LO  = 12'b0010_0000_0000,
    PH_RA_SET = 12'b0100_0000_0000,
    PH_RA_CLK = 12'b1000_0000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  action_latched, action_latched_next;
  logic [11:0] tick_count, tick_count_next;
  logic [15:0] poll_count, poll_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [2:0]  ts_step, ts_step_next;
  logic [3:0]  reset_clock_count, reset_clock_count_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] result_word, result_word_next;
  logic [7:0]  result_check, result_check_next;
  logic [1:0]  errors, errors_next;

  logic [11:0] half;
  logic [15:0] limit;
  logic [15:0] poll_inc;
  logic [3:0]  rcc_inc;
  logic        step_end;
  logic        finish;
  logic        add_err;

  assign half     = (cfg.half_period_ticks == 12'd0) ? 12'd1 : cfg.half_period_ticks;
  assign limit    = (cfg.ready_timeout_polls == 16'd0) ? 16'd1 : cfg.ready_timeout_polls;
  assign poll_inc = poll_count + 16'd1;
  assign rcc_inc  = reset_clock_count + 4'd1;
  assign step_end = ({1'b0, tick_count} + 13'd1) >= {1'b0, half};

  always_comb begin
    phase_next             = phase;
    action_latched_next    = action_latched;
    tick_count_next        = tick_count;
    poll_count_next        = poll_count;
    bit_index_next         = bit_index;
    ts_step_next           = ts_step;
    reset_clock_count_next = reset_clock_count;
    byte_index_next        = byte_index;
    shift_byte_next        = shift_byte;
    result_word_next       = result_word;
    result_check_next      = result_check;
    errors_next            = errors;
    finish                 = 1'b0;
    add_err                = 1'b0;

    if (phase == PH_IDLE) begin
      if (tick.start_req) begin
        action_latched_next    = tick.action;
        errors_next            = 2'd0;
        poll_count_next        = 16'd0;
        tick_count_next        = 12'd0;
        reset_clock_count_next = 4'd0;
        ts_step_next           = 3'd0;
        phase_next = (tick.action == ACT_CONN_RESET || tick.action == ACT_SOFT_RESET)
                     ? PH_RST_HI : PH_TS;
      end
    end else if (!step_end) begin
      tick_count_next = tick_count + 12'd1;
    end else begin
      tick_count_next = 12'd0;
      unique case (phase)
        PH_RST_HI: phase_next = PH_RST_LO;
        PH_RST_LO: begin
          reset_clock_count_next = rcc_inc;
          ts_step_next           = 3'd0;
          phase_next = (rcc_inc >= RESET_CLOCKS) ? PH_TS : PH_RST_HI;
        end
        PH_TS: begin
          if (ts_step != TS_LAST) begin
            ts_step_next = ts_step + 3'd1;
          end else if (action_latched == ACT_CONN_RESET) begin
            finish = 1'b1;
          end else begin
            unique case (action_latched)
              ACT_SOFT_RESET: shift_byte_next = cfg.soft_reset_command;
              ACT_TEMP:       shift_byte_next = cfg.temperature_command;
              default:        shift_byte_next = cfg.humidity_command;
            endcase
            bit_index_next = 3'd7;
            phase_next     = PH_WB_HI;
          end
        end
        PH_WB_HI: phase_next = PH_WB_LO;
        PH_WB_LO: begin
          if (bit_index == 3'd0) begin
            phase_next = PH_WACK;
          end else begin
            bit_index_next = bit_index - 3'd1;
            phase_next     = PH_WB_HI;
          end
        end
        PH_WACK: begin
          add_err = tick.data_sample;
          if (action_latched == ACT_SOFT_RESET) begin
            finish = 1'b1;
          end else begin
            poll_count_next = 16'd0;
            phase_next      = PH_POLL;
          end
        end
        PH_POLL: begin
          if (!tick.data_sample) begin
            byte_index_next = 2'd0;
            bit_index_next  = 3'd7;
            shift_byte_next = 8'd0;
            phase_next      = PH_RB_HI;
          end else begin
            poll_count_next = poll_inc;
            if (poll_inc >= limit) begin
              add_err         = 1'b1;
              byte_index_next = 2'd0;
              bit_index_next  = 3'd7;
              shift_byte_next = 8'd0;
              phase_next      = PH_RB_HI;
            end
          end
        end
        PH_RB_HI: begin
          if (tick.data_sample) shift_byte_next[bit_index] = 1'b1;
          phase_next = PH_RB_LO;
        end
        PH_RB_LO: begin
          if (bit_index != 3'd0) begin
            bit_index_next = bit_index - 3'd1;
            phase_next     = PH_RB_HI;
          end else begin
            priority if (byte_index == 2'd0) begin
              result_word_next[15:8] = shift_byte;
            end else if (byte_index == 2'd1) begin
              result_word_next[7:0] = shift_byte;
            end else begin
              result_check_next = shift_byte;
            end
            phase_next = PH_RA_SET;
          end
        end
        PH_RA_SET: phase_next = PH_RA_CLK;
        PH_RA_CLK: begin
          if (byte_index >= 2'd2) begin
            finish = 1'b1;
          end else begin
            byte_index_next = byte_index + 2'd1;
            bit_index_next  = 3'd7;
            shift_byte_next = 8'd0;
            phase_next      = PH_RB_HI;
          end
        end
        default: finish = 1'b1;
      endcase
    end

    // saturate at three
    if (add_err && errors != 2'd3) errors_next = errors + 2'd1;
    if (finish) phase_next = PH_IDLE;
  end

  // pin levels come from the phase in effect when the tick starts
  always_comb begin
    res.clock_level       = 1'b0;
    res.data_drive_enable = 1'b1;
    res.data_level        = 1'b1;
    unique case (phase)
      PH_RST_HI: res.clock_level = 1'b1;
      PH_TS: begin
        res.clock_level = ts_clock(ts_step);
        res.data_level  = ts_data(ts_step);
      end
      PH_WB_HI, PH_WB_LO: begin
        res.clock_level = (phase == PH_WB_HI);
        res.data_level  = shift_byte[bit_index];
      end
      PH_WACK, PH_RB_HI: begin
        res.clock_level       = 1'b1;
        res.data_drive_enable = 1'b0;
        res.data_level        = 1'b0;
      end
      PH_POLL, PH_RB_LO: begin
        res.data_drive_enable = 1'b0;
        res.data_level        = 1'b0;
      end
      PH_RA_SET, PH_RA_CLK: begin
        res.clock_level = (phase == PH_RA_CLK);
        res.data_level  = (byte_index >= 2'd2);
      end
      default: ;
    endcase
    res.busy_res    = (phase != PH_IDLE);
    res.done_res    = finish;
    res.measurement = result_word_next;
    res.check_byte  = result_check_next;
    res.error_count = errors_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      action_latched    <= 2'd0;
      tick_count        <= 12'd0;
      poll_count        <= 16'd0;
      bit_index         <= 3'd0;
      ts_step           <= 3'd0;
      reset_clock_count <= 4'd0;
      byte_index        <= 2'd0;
      shift_byte        <= 8'd0;
      result_word       <= 16'd0;
      result_check      <= 8'd0;
      errors            <= 2'd0;
    end else if (step_en) begin
      phase             <= phase_next;
      action_latched    <= action_latched_next;
      tick_count        <= tick_count_next;
      poll_count        <= poll_count_next;
      bit_index         <= bit_index_next;
      ts_step           <= ts_step_next;
      reset_clock_count <= reset_clock_count_next;
      byte_index        <= byte_index_next;
      shift_byte        <= shift_byte_next;
      result_word       <= result_word_next;
      result_check      <= result_check_next;
      errors            <= errors_next;
    end
  end

endmodule

// ===== design/two_wire_humidity_sensor_master_top.sv =====
// Channel   Direction  Handshake         Contents
// s_axis    in         tvalid/tready     one bus tick: DATA sample, start request, action
// m_axis    out        tvalid/tready     pin levels, status and results for that tick
// apb       in/out     psel/penable      five configuration registers at 4*i
//
// One tick is taken every clock cycle while s_axis_tready is high. A tick
// waits in the input register until the sequencer step turns it into a
// result in the output register, from which the result is offered.
// Reset clears the sequencer to idle and both valid flags; registers return
// to their defaults. A stall on m_axis freezes the sequencer and backs up
// into s_axis_tready; no tick is lost while a result waits.
module two_wire_humidity_sensor_master_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] data_sample
  input  logic [2:0]                      s_axis_tuser,  // [0] start_req, [2:1] action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] clock_level, [1] data_drive_enable, [2] data_level, [3] busy_res,
  // [4] done_res, [20:5] measurement, [28:21] check_byte, [30:29] error_count
  output logic [31:0]                     m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [twhsm_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import twhsm_pkg::*;

  cfg_t    cfg;
  tick_t   in_tick;
  logic    in_valid;
  result_t res;
  logic    advance;

  twhsm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Step the sequencer when a tick is held and the output register is free
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register: hold the tick until its step runs
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tick.start_req   <= s_axis_tuser[0];
      in_tick.action      <= s_axis_tuser[2:1];
      in_tick.data_sample <= s_axis_tdata[0];
    end
  end

  twhsm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .tick    (in_tick),
    .cfg     (cfg),
    .res     (res)
  );

  // Output register: load on each step, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {1'b0, res.error_count, res.check_byte, res.measurement,
                       res.done_res, res.busy_res, res.data_level,
                       res.data_drive_enable, res.clock_level};
    end
  end

endmodule
